// ----- rtl/rbsi_pkg.sv -----
`timescale 1ns / 1ps
package rbsi_pkg;

  localparam int COORD_W     = 32;
  localparam int DIST_W      = 48;
  localparam int FRAC_W      = 16;
  localparam int NUM_MAG_W   = 32;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = DIST_W / DIV_BITS;
  localparam int AXES        = 3;
  localparam int BOX_REGS    = 6;
  localparam int CFG_IDX_W   = 3;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_Z_LOW  = 3'd4,
    REG_Z_HIGH = 3'd5
  } box_reg_t;

  // per-axis flags that ride beside the dividers
  typedef struct packed {
    logic dir_zero;
    logic outside;
    logic neg_in;
    logic neg_out;
  } axis_side_t;

  typedef axis_side_t [AXES-1:0] side_t;

  function automatic logic signed [DIST_W-1:0] sat_dist(input logic [DIST_W-1:0] mag,
                                                       input logic neg);
    logic signed [DIST_W-1:0] res;
    if (neg) begin
      if (mag > DIST_MIN) res = DIST_MIN;
      else res = -$signed(mag);
    end else begin
      if (mag > DIST_MAX) res = DIST_MAX;
      else res = $signed(mag);
    end
    return res;
  endfunction

endpackage

// ----- rtl/ray_box_slab_intersect.sv -----
`timescale 1ns / 1ps
// Ray against axis-aligned box, slab method.
// Box bounds: write registers over cfg_valid/cfg_index/cfg_data while no ray
// is in flight (x low, x high, y low, y high, z low, z high; indexes 0..5,
// higher indexes are dropped). cfg_ready is always high.
// Rays enter as beats on in_*: origin x,y,z and direction x,y,z, Q16.16.
// Each ray gives one beat on out_*: hit flag, near and far distance, Q32.16,
// with the extreme codes standing for minus and plus infinity.
// Between the input beat and the result beat a ray passes one prep
// stage, twelve divider stages of four quotient bits each, one saturation
// stage, two fold stages and the output register. Six divider pipelines run
// side by side, so one ray enters every cycle while the output is not
// stalled, and the sustained rate is one ray per cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// empty stages do not hold back the input, which stays ready as long as the
// output register is free or being taken.
// Reset clears the box registers to zero and empties the pipeline.
module ray_box_slab_intersect (
  input  logic                                clk,
  input  logic                                rst_n,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 32 bits each
  input  logic [6*rbsi_pkg::COORD_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // hit, near_dist[47:0], far_dist[47:0], 7 zero bits
  output logic [103:0]                        out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbsi_pkg::COORD_W-1:0]        cfg_data
);
  import rbsi_pkg::*;

  localparam int NSTG    = DIV_STAGES + 5;
  localparam int ST_SAT  = DIV_STAGES + 1;
  localparam int ST_F1   = DIV_STAGES + 2;
  localparam int ST_OUT  = DIV_STAGES + 4;

  logic signed [COORD_W-1:0] box_r [BOX_REGS];
  logic [NSTG-1:0]           v_r;
  logic                      en;

  assign cfg_ready = 1'b1;
  assign en        = !v_r[ST_OUT] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BOX_REGS; i++) box_r[i] <= '0;
    end else if (cfg_valid && cfg_index <= REG_Z_HIGH) begin
      box_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_tvalid};
    end
  end

  // prep stage: pick bounds by direction sign, form numerators and magnitudes
  logic [NUM_MAG_W-1:0] nin_r  [AXES];
  logic [NUM_MAG_W-1:0] nout_r [AXES];
  logic [COORD_W-1:0]   dmag_r [AXES];
  side_t                side_r [DIV_STAGES+1];
  logic [NUM_MAG_W-1:0] nin_nxt  [AXES];
  logic [NUM_MAG_W-1:0] nout_nxt [AXES];
  logic [COORD_W-1:0]   dmag_nxt [AXES];
  side_t                side_nxt;

  always_comb begin
    logic signed [COORD_W-1:0] lo, hi, org, dir, bin, bout;
    logic signed [COORD_W:0]   num_in, num_out, abs_in, abs_out;
    for (int a = 0; a < AXES; a++) begin
      lo  = box_r[2*a];
      hi  = box_r[2*a+1];
      org = in_tdata[a*COORD_W +: COORD_W];
      dir = in_tdata[(a+AXES)*COORD_W +: COORD_W];
      bin  = dir[COORD_W-1] ? hi : lo;
      bout = dir[COORD_W-1] ? lo : hi;
      num_in  = {bin[COORD_W-1], bin} - {org[COORD_W-1], org};
      num_out = {bout[COORD_W-1], bout} - {org[COORD_W-1], org};
      abs_in  = num_in[COORD_W] ? -num_in : num_in;
      abs_out = num_out[COORD_W] ? -num_out : num_out;
      nin_nxt[a]  = abs_in[NUM_MAG_W-1:0];
      nout_nxt[a] = abs_out[NUM_MAG_W-1:0];
      dmag_nxt[a] = dir[COORD_W-1] ? COORD_W'(-dir) : dir;
      side_nxt[a].dir_zero = (dir == '0);
      side_nxt[a].outside  = (org < lo) || (org > hi);
      side_nxt[a].neg_in   = num_in[COORD_W] ^ dir[COORD_W-1];
      side_nxt[a].neg_out  = num_out[COORD_W] ^ dir[COORD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        nin_r[a]  <= nin_nxt[a];
        nout_r[a] <= nout_nxt[a];
        dmag_r[a] <= dmag_nxt[a];
      end
      side_r[0] <= side_nxt;
      for (int s = 1; s <= DIV_STAGES; s++) side_r[s] <= side_r[s-1];
    end
  end

  logic [DIST_W-1:0] qin  [AXES];
  logic [DIST_W-1:0] qout [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    rbsi_div u_div_in (
      .clk(clk), .en(en), .num_mag(nin_r[a]), .den(dmag_r[a]), .quo(qin[a])
    );
    rbsi_div u_div_out (
      .clk(clk), .en(en), .num_mag(nout_r[a]), .den(dmag_r[a]), .quo(qout[a])
    );
  end

  // saturation stage
  logic signed [DIST_W-1:0] tin_r  [AXES];
  logic signed [DIST_W-1:0] tout_r [AXES];
  side_t                    sat_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        tin_r[a]  <= sat_dist(qin[a], side_r[DIV_STAGES][a].neg_in);
        tout_r[a] <= sat_dist(qout[a], side_r[DIV_STAGES][a].neg_out);
      end
      sat_side_r <= side_r[DIV_STAGES];
    end
  end

  // fold x and y; a miss on an axis freezes the distances from that axis on
  logic signed [DIST_W-1:0] near1_r, far1_r, tin2_r, tout2_r;
  logic [AXES-1:0]          miss1_r;
  logic                     dz2_r;

  always_ff @(posedge clk) begin
    logic signed [DIST_W-1:0] nr, fr;
    logic [AXES-1:0] miss;
    if (en) begin
      nr = DIST_MIN;
      fr = DIST_MAX;
      for (int a = 0; a < AXES; a++)
        miss[a] = sat_side_r[a].dir_zero && sat_side_r[a].outside;
      if (!sat_side_r[0].dir_zero) begin
        nr = tin_r[0];
        fr = tout_r[0];
      end
      if (!miss[0] && !sat_side_r[1].dir_zero) begin
        if (tin_r[1] > nr) nr = tin_r[1];
        if (tout_r[1] < fr) fr = tout_r[1];
      end
      near1_r <= nr;
      far1_r  <= fr;
      tin2_r  <= tin_r[2];
      tout2_r <= tout_r[2];
      miss1_r <= miss;
      dz2_r   <= sat_side_r[2].dir_zero;
    end
  end

  // fold z
  logic signed [DIST_W-1:0] near2_r, far2_r;
  logic                     miss2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      near2_r <= near1_r;
      far2_r  <= far1_r;
      if (!miss1_r[0] && !miss1_r[1] && !dz2_r) begin
        if (tin2_r > near1_r) near2_r <= tin2_r;
        if (tout2_r < far1_r) far2_r <= tout2_r;
      end
      miss2_r <= |miss1_r;
    end
  end

  // output register
  logic                     hit_r;
  logic signed [DIST_W-1:0] near_r, far_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= !miss2_r && (near2_r < far2_r);
      near_r <= near2_r;
      far_r  <= far2_r;
    end
  end

  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = {7'b0, far_r, near_r, hit_r};

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hit_r |-> near_r < far_r)
    else $error("hit reported with near not below far");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat not in prep stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(v_r) && $stable(out_tdata))
    else $error("pipeline moved during output stall");

  a_sat_sel: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[ST_SAT] && sat_side_r[0].dir_zero && sat_side_r[1].dir_zero |=>
      v_r[ST_F1] && near1_r == DIST_MIN && far1_r == DIST_MAX)
    else $error("zero-direction axes changed the distances");

endmodule

// ----- rtl/rbsi_div.sv -----
`timescale 1ns / 1ps
module rbsi_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [rbsi_pkg::NUM_MAG_W-1:0]   num_mag,
  input  logic [rbsi_pkg::COORD_W-1:0]     den,
  output logic [rbsi_pkg::DIST_W-1:0]      quo
);
  import rbsi_pkg::*;

  logic [COORD_W:0]   rem_r [DIV_STAGES];
  logic [DIST_W-1:0]  dvd_r [DIV_STAGES];
  logic [COORD_W-1:0] den_r [DIV_STAGES];

  // restoring division, DIV_BITS quotient bits per stage; dividend bits
  // shift out of the top of dvd while quotient bits shift in at the bottom
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [COORD_W:0]   rem_in;
    logic [DIST_W-1:0]  dvd_in;
    logic [COORD_W-1:0] den_in;
    logic [COORD_W:0]   rem_nxt;
    logic [DIST_W-1:0]  dvd_nxt;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = {num_mag, {FRAC_W{1'b0}}};
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign dvd_in = dvd_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      dvd_nxt = dvd_in;
      for (int k = 0; k < DIV_BITS; k++) begin
        rem_nxt = {rem_nxt[COORD_W-1:0], dvd_nxt[DIST_W-1]};
        dvd_nxt = {dvd_nxt[DIST_W-2:0], 1'b0};
        if (rem_nxt >= {1'b0, den_in}) begin
          rem_nxt = rem_nxt - {1'b0, den_in};
          dvd_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        dvd_r[s] <= dvd_nxt;
        den_r[s] <= den_in;
      end
    end
  end

  assign quo = dvd_r[DIV_STAGES-1];

endmodule
